// ----- design/dlsc_pkg.sv -----
`timescale 1ns / 1ps

package dlsc_pkg;

  // Sequencer phases of the calibration loop
  localparam logic [2:0] PH_POWER   = 3'd0;
  localparam logic [2:0] PH_LAUNCH_S = 3'd1;
  localparam logic [2:0] PH_WAIT_S  = 3'd2;
  localparam logic [2:0] PH_LAUNCH_L = 3'd3;
  localparam logic [2:0] PH_WAIT_L  = 3'd4;
  localparam logic [2:0] PH_SCALE   = 3'd5;

  // Status codes
  localparam logic [1:0] STAT_BUSY    = 2'd0;
  localparam logic [1:0] STAT_APPLIED = 2'd1;
  localparam logic [1:0] STAT_RANGE   = 2'd2;

  // Measurement taps
  localparam logic [7:0] TAP_SHORT = 8'h50;
  localparam logic [7:0] TAP_LONG  = 8'hC8;

  // Scale limits
  localparam logic [15:0] SCALE_SAT   = 16'hFFFF;
  localparam logic [15:0] SCALE_LIMIT = 16'h00FF;

  // Divider geometry: dividend 2*240*a*b + D, divisor 2*D, D = 65535*(b-a)
  localparam int unsigned NUM_W = 42;
  localparam int unsigned DEN_W = 33;

  // Beat widths
  localparam int unsigned S_TDATA_W = 24;
  localparam int unsigned M_TDATA_W = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_PREP,
    ST_DIV,
    ST_FIN
  } dlsc_state_e;

endpackage

// ----- design/delay_line_scale_calibrator_unit.sv -----
`timescale 1ns / 1ps

// Channel  Dir  Width  tdata fields (lsb first)
// s_axis   in   24     busy_req[0], measure_count[16:1], zero pad
// m_axis   out  32     status[1:0], scale_factor[17:2], start_measure[18],
//                      tap_setting[26:19], step_write[27], power_up[28], zero pad
//
// One result beat per input beat. Every phase but the scale phase answers in the
// cycle after the input beat. The scale phase with valid counts runs one multiply,
// one setup, 42 restoring-divide steps on a shared 34-bit subtractor, then one
// saturate/report step. Input is not ready while the divider runs or while an
// unread result blocks the output register.
// rst_ni clears the phase, the kept counts, the scale and the output valid.

module delay_line_scale_calibrator_unit
  import dlsc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,  // busy_req, measure_count
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata   // status, scale_factor, start_measure,
                                              // tap_setting, step_write, power_up
);

  localparam int unsigned CNT_W = $clog2(NUM_W);

  dlsc_state_e state_q, state_d;
  logic [2:0]  phase_q, phase_d;
  logic [15:0] cnt_s_q, cnt_s_d;
  logic [15:0] cnt_l_q, cnt_l_d;
  logic [15:0] scale_q, scale_d;
  logic        m_valid_q, m_valid_d;

  // Output register fields
  logic [1:0]  o_status_q, o_status_d;
  logic [15:0] o_scale_q, o_scale_d;
  logic        o_start_q, o_start_d;
  logic [7:0]  o_tap_q, o_tap_d;
  logic        o_wr_q, o_wr_d;
  logic        o_pwr_q, o_pwr_d;

  // Arithmetic datapath
  logic [31:0]      prod_q, prod_d;
  logic [15:0]      diff_q, diff_d;
  logic [NUM_W-1:0] dq_q, dq_d;
  logic [DEN_W-1:0] dv_q, dv_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [CNT_W-1:0] step_q, step_d;

  logic             in_busy;
  logic [15:0]      in_count;
  logic             s_accept;
  logic [NUM_W-1:0] num480;
  logic [31:0]      den;
  logic [DEN_W:0]   trial;
  logic             trial_ge;
  logic [15:0]      q_sat;

  assign in_busy  = s_axis_tdata[0];
  assign in_count = s_axis_tdata[16:1];

  assign s_axis_tready = (state_q == ST_IDLE) && (!m_valid_q || m_axis_tready);
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {3'b000, o_pwr_q, o_wr_q, o_tap_q, o_start_q, o_scale_q, o_status_q};

  // Dividend and divisor setup terms
  assign num480 = (NUM_W'(prod_q) << 9) - (NUM_W'(prod_q) << 5);
  assign den    = (32'(diff_q) << 16) - 32'(diff_q);

  // Shared subtractor: one restoring-divide step
  assign trial    = {rem_q, dq_q[NUM_W-1]};
  assign trial_ge = trial >= {1'b0, dv_q};

  // Saturated quotient
  assign q_sat = (|dq_q[NUM_W-1:16]) ? SCALE_SAT : dq_q[15:0];

  // Control and payload registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      phase_q   <= PH_POWER;
      cnt_s_q   <= '0;
      cnt_l_q   <= '0;
      scale_q   <= '0;
      m_valid_q <= 1'b0;
      step_q    <= '0;
    end else begin
      state_q   <= state_d;
      phase_q   <= phase_d;
      cnt_s_q   <= cnt_s_d;
      cnt_l_q   <= cnt_l_d;
      scale_q   <= scale_d;
      m_valid_q <= m_valid_d;
      step_q    <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    o_status_q <= o_status_d;
    o_scale_q  <= o_scale_d;
    o_start_q  <= o_start_d;
    o_tap_q    <= o_tap_d;
    o_wr_q     <= o_wr_d;
    o_pwr_q    <= o_pwr_d;
    prod_q     <= prod_d;
    diff_q     <= diff_d;
    dq_q       <= dq_d;
    dv_q       <= dv_d;
    rem_q      <= rem_d;
  end

  // Sequencer: next state and outputs
  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    cnt_s_d    = cnt_s_q;
    cnt_l_d    = cnt_l_q;
    scale_d    = scale_q;
    m_valid_d  = m_valid_q && !m_axis_tready;
    o_status_d = o_status_q;
    o_scale_d  = o_scale_q;
    o_start_d  = o_start_q;
    o_tap_d    = o_tap_q;
    o_wr_d     = o_wr_q;
    o_pwr_d    = o_pwr_q;
    prod_d     = prod_q;
    diff_d     = diff_q;
    dq_d       = dq_q;
    dv_d       = dv_q;
    rem_d      = rem_q;
    step_d     = step_q;

    case (state_q)
      ST_IDLE: begin
        if (s_accept) begin
          // most phases answer right away
          m_valid_d  = 1'b1;
          o_status_d = STAT_BUSY;
          o_start_d  = 1'b0;
          o_tap_d    = '0;
          o_wr_d     = 1'b0;
          o_pwr_d    = 1'b0;
          case (phase_q)
            PH_POWER: begin
              o_pwr_d = 1'b1;
              cnt_s_d = '0;
              cnt_l_d = '0;
              phase_d = PH_LAUNCH_S;
            end
            PH_LAUNCH_S: begin
              o_start_d = 1'b1;
              o_tap_d   = TAP_SHORT;
              phase_d   = PH_WAIT_S;
            end
            PH_WAIT_S: begin
              if (!in_busy) begin
                cnt_s_d = in_count;
                phase_d = PH_LAUNCH_L;
              end
            end
            PH_LAUNCH_L: begin
              o_start_d = 1'b1;
              o_tap_d   = TAP_LONG;
              phase_d   = PH_WAIT_L;
            end
            PH_WAIT_L: begin
              if (!in_busy) begin
                cnt_l_d = in_count;
                phase_d = PH_SCALE;
              end
            end
            PH_SCALE: begin
              // a = long count, b = short count
              if (cnt_s_q <= cnt_l_q || cnt_l_q == '0) begin
                scale_d    = SCALE_SAT;
                o_status_d = STAT_RANGE;
                phase_d    = PH_LAUNCH_S;
              end else begin
                m_valid_d = 1'b0;
                state_d   = ST_MUL;
              end
            end
            default: begin
              phase_d = PH_LAUNCH_S;
            end
          endcase
          o_scale_d = scale_d;
        end
      end
      ST_MUL: begin
        prod_d  = {16'b0, cnt_l_q} * {16'b0, cnt_s_q};
        diff_d  = cnt_s_q - cnt_l_q;
        state_d = ST_PREP;
      end
      ST_PREP: begin
        dq_d    = num480 + NUM_W'(den);
        dv_d    = {den, 1'b0};
        rem_d   = '0;
        step_d  = CNT_W'(NUM_W - 1);
        state_d = ST_DIV;
      end
      ST_DIV: begin
        rem_d  = trial_ge ? DEN_W'(trial - {1'b0, dv_q}) : trial[DEN_W-1:0];
        dq_d   = {dq_q[NUM_W-2:0], trial_ge};
        step_d = step_q - 1'b1;
        if (step_q == '0) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        scale_d    = q_sat;
        m_valid_d  = 1'b1;
        o_scale_d  = q_sat;
        o_start_d  = 1'b0;
        o_tap_d    = '0;
        o_pwr_d    = 1'b0;
        o_status_d = (q_sat > SCALE_LIMIT) ? STAT_RANGE : STAT_APPLIED;
        o_wr_d     = (q_sat <= SCALE_LIMIT);
        phase_d    = PH_LAUNCH_S;
        state_d    = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  // No input beat while the divider works
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !s_axis_tready)
    else $error("input ready during scale computation");

  // Last divide step leads to the report cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && step_q == '0) |=> (state_q == ST_FIN))
    else $error("divider did not finish");

  // Step write only with an applied scale
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> (o_wr_q == (o_status_q == STAT_APPLIED)))
    else $error("step write and status disagree");

  // Tap is shown only with a launch
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !o_start_q) |-> (o_tap_q == '0))
    else $error("tap without launch");

  // Phase stays within the loop
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= PH_SCALE)
    else $error("phase out of loop");

  // Report cycle always raises the output valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN) |=> m_valid_q)
    else $error("scale result lost");
`endif

endmodule

// ----- dv/dlsc_scale_checker.sv -----
`timescale 1ns / 1ps

module dlsc_scale_checker
  import dlsc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_tvalid_i,
  input  logic                 s_tready_i,
  input  logic [S_TDATA_W-1:0] s_tdata_i,
  input  logic                 m_tvalid_i,
  input  logic                 m_tready_i,
  input  logic [M_TDATA_W-1:0] m_tdata_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  localparam longint unsigned SCALE_NUM  = 240;
  localparam longint unsigned COUNT_FULL = 65535;
  localparam int              PRINT_CAP  = 200;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] scale;
    logic        start;
    logic [7:0]  tap;
    logic        wr;
    logic        pwr;
  } poll_result_t;

  // Shadow copy of the sequencer
  logic [2:0]   seq_phase;
  logic [15:0]  short_cnt;
  logic [15:0]  long_cnt;
  logic [15:0]  scale_reg;
  poll_result_t result_q[$];
  int           issued;
  int           retired;
  int           out_beats;

  assign pending_o = issued - retired;

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    if (fail_count_o < PRINT_CAP) begin
      $display("[%0t] result beat %0d: %s expected 0x%0h got 0x%0h",
               $realtime, out_beats, what, want, got);
    end
    fail_count_o++;
  endtask

  // round(240*a*b / (65535*(b-a))) with half-up rounding, saturated
  function automatic logic [15:0] scale_of(input logic [15:0] a, input logic [15:0] b,
                                           output logic out_of_range);
    longint unsigned num;
    longint unsigned den;
    longint unsigned q;
    if (b <= a || a == 16'd0) begin
      out_of_range = 1'b1;
      return SCALE_SAT;
    end
    num = SCALE_NUM * longint'(a) * longint'(b);
    den = COUNT_FULL * longint'(b - a);
    q   = (2 * num + den) / (2 * den);
    if (q > longint'(SCALE_SAT)) q = longint'(SCALE_SAT);
    out_of_range = (q > longint'(SCALE_LIMIT));
    return q[15:0];
  endfunction

  // Advance the shadow sequencer by one poll
  function automatic poll_result_t next_result(input logic busy, input logic [15:0] cnt);
    poll_result_t r;
    logic         bad;
    r = '0;
    r.status = STAT_BUSY;
    case (seq_phase)
      PH_POWER: begin
        r.pwr     = 1'b1;
        short_cnt = '0;
        long_cnt  = '0;
        seq_phase = PH_LAUNCH_S;
      end
      PH_LAUNCH_S: begin
        r.start   = 1'b1;
        r.tap     = TAP_SHORT;
        seq_phase = PH_WAIT_S;
      end
      PH_WAIT_S: begin
        if (!busy) begin
          short_cnt = cnt;
          seq_phase = PH_LAUNCH_L;
        end
      end
      PH_LAUNCH_L: begin
        r.start   = 1'b1;
        r.tap     = TAP_LONG;
        seq_phase = PH_WAIT_L;
      end
      PH_WAIT_L: begin
        if (!busy) begin
          long_cnt  = cnt;
          seq_phase = PH_SCALE;
        end
      end
      PH_SCALE: begin
        scale_reg = scale_of(long_cnt, short_cnt, bad);
        if (bad) begin
          r.status = STAT_RANGE;
        end else begin
          r.status = STAT_APPLIED;
          r.wr     = 1'b1;
        end
        seq_phase = PH_LAUNCH_S;
      end
      default: begin
        seq_phase = PH_LAUNCH_S;
      end
    endcase
    r.scale = scale_reg;
    return r;
  endfunction

  // Predict on input beats, compare on output beats
  always @(posedge clk_i or negedge rst_ni) begin
    poll_result_t want;
    poll_result_t got;
    if (!rst_ni) begin
      seq_phase    = PH_POWER;
      short_cnt    = '0;
      long_cnt     = '0;
      scale_reg    = '0;
      result_q.delete();
      issued       = 0;
      retired      = 0;
      out_beats    = 0;
      fail_count_o = 0;
    end else begin
      if (s_tvalid_i && s_tready_i) begin
        result_q.push_back(next_result(s_tdata_i[0], s_tdata_i[16:1]));
        issued++;
      end
      if (m_tvalid_i && m_tready_i) begin
        got.status = m_tdata_i[1:0];
        got.scale  = m_tdata_i[17:2];
        got.start  = m_tdata_i[18];
        got.tap    = m_tdata_i[26:19];
        got.wr     = m_tdata_i[27];
        got.pwr    = m_tdata_i[28];
        if (result_q.size() == 0) begin
          report_mismatch("unexpected beat, tdata", 0, m_tdata_i);
        end else begin
          want = result_q.pop_front();
          retired++;
          if (got.status !== want.status) report_mismatch("status", want.status, got.status);
          if (got.scale !== want.scale) report_mismatch("scale_factor", want.scale, got.scale);
          if (got.start !== want.start) report_mismatch("start_measure", want.start, got.start);
          if (got.tap !== want.tap) report_mismatch("tap_setting", want.tap, got.tap);
          if (got.wr !== want.wr) report_mismatch("step_write", want.wr, got.wr);
          if (got.pwr !== want.pwr) report_mismatch("power_up", want.pwr, got.pwr);
          if (m_tdata_i[M_TDATA_W-1:29] !== '0) begin
            report_mismatch("tdata pad", 0, m_tdata_i[M_TDATA_W-1:29]);
          end
        end
        out_beats++;
      end
    end
  end

endmodule

// ----- dv/tb_delay_line_scale_calibrator_unit.sv -----
`timescale 1ns / 1ps

module tb_delay_line_scale_calibrator_unit
  import dlsc_pkg::*;
();

  localparam int POLL_TARGET = 1150;
  localparam int HOLD_CYCLES = 300;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;

  int fail_count;
  int pending;
  int polls_sent;
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_pending;

  delay_line_scale_calibrator_unit uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  dlsc_scale_checker scoreboard (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // 100 MHz clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_pending) begin
        hold_pending = 1'b0;
        repeat (HOLD_CYCLES) begin
          m_axis_tready <= 1'b0;
          @(negedge clk_i);
        end
      end
      m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // One poll beat; called and returns at a falling edge
  task automatic send_poll(input logic busy, input logic [15:0] cnt);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(S_TDATA_W-17){1'b0}}, cnt, busy};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    polls_sent++;
  endtask

  function automatic logic [15:0] noise16();
    return 16'($urandom());
  endfunction

  // One full loop: launch short, wait, launch long, wait, scale
  task automatic run_loop(input logic [15:0] cnt_s, input logic [15:0] cnt_l,
                          input int busy_s, input int busy_l);
    send_poll(1'($urandom_range(0, 1)), noise16());
    repeat (busy_s) send_poll(1'b1, noise16());
    send_poll(1'b0, cnt_s);
    send_poll(1'($urandom_range(0, 1)), noise16());
    repeat (busy_l) send_poll(1'b1, noise16());
    send_poll(1'b0, cnt_l);
    send_poll(1'($urandom_range(0, 1)), noise16());
  endtask

  // Random loop; most pairs land in the usable scale range
  task automatic run_random_loop();
    logic [15:0]     cnt_s;
    logic [15:0]     cnt_l;
    longint unsigned lmax;
    int              kind;
    int              wait_s;
    int              wait_l;
    kind   = $urandom_range(0, 9);
    wait_s = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 10) : $urandom_range(0, 2);
    wait_l = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 10) : $urandom_range(0, 2);
    if (kind <= 5) begin
      cnt_s = $urandom_range(0, 1) ? 16'($urandom_range(2, 65535))
                                   : 16'($urandom_range(2, 1000));
      lmax  = (longint'(69632) * cnt_s) / (longint'(cnt_s) + 69632);
      if (lmax >= cnt_s) lmax = 64'(cnt_s) - 1;
      if (lmax < 1) lmax = 1;
      // sometimes sit right on the 255/256 boundary
      if ($urandom_range(0, 3) == 0) begin
        cnt_l = (lmax > 3) ? 16'(lmax - $urandom_range(0, 3)) : 16'(lmax);
      end else begin
        cnt_l = 16'($urandom_range(1, int'(lmax)));
      end
    end else if (kind == 6) begin
      cnt_s = noise16();
      case ($urandom_range(0, 2))
        0:       cnt_l = 16'd0;
        1:       cnt_l = cnt_s;
        default: cnt_l = 16'($urandom_range(int'(cnt_s), 65535));
      endcase
    end else begin
      cnt_s = noise16();
      cnt_l = noise16();
    end
    run_loop(cnt_s, cnt_l, wait_s, wait_l);
  endtask

  // Stop offering beats and wait until every result is back
  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
  endtask

  initial begin
    int phase_goal;
    int ph;
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    hold_pending   = 1'b0;
    polls_sent     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: power-up, saturation, degenerate pairs, tiny scale
    send_poll(1'b1, 16'hFFFF);
    run_loop(16'hFFFF, 16'hFFFE, 1, 1);
    run_loop(16'h0000, 16'h0000, 0, 0);
    run_loop(16'hFFFF, 16'h0000, 0, 0);
    run_loop(16'd100, 16'd100, 0, 0);
    run_loop(16'd3, 16'd2, 0, 0);

    // Random loops under each idling mix
    for (ph = 0; ph < 8; ph++) begin
      wait_drain();
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
        default: begin send_idle_pct = 36; recv_stall_pct = 36; end
      endcase
      if (ph == 2) hold_pending = 1'b1;
      phase_goal = 26 + ((POLL_TARGET - 26) * (ph + 1)) / 8;
      while (polls_sent < phase_goal) run_random_loop();
    end

    wait_drain();
    repeat (100) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/dlsc_pkg.sv
design/delay_line_scale_calibrator_unit.sv
dv/dlsc_scale_checker.sv
dv/tb_delay_line_scale_calibrator_unit.sv
